>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define AM_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off while reset is asserted
`define AM_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication that also holds through reset
`define AM_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/pdnm_pkg.sv
// ----------------------------------------------------------------------------
// pdnm_pkg
// shared constants, types and tuning rom for the dds note mixer
// ----------------------------------------------------------------------------
package pdnm_pkg;

  localparam int NOTES      = 12;
  localparam int BOARDS_DEF = 4;
  localparam int MAX_BOARDS = 4;
  localparam int NOTE_W     = 4;
  localparam int TBL_AW     = 10;
  localparam int TBL_DEPTH  = 1 << TBL_AW;
  localparam int SMP_W      = 16;
  localparam int PH_W       = 32;
  localparam int KEY_W      = 48;
  localparam int KEY_POS_W  = 6;
  localparam int SHF_W      = 4;
  localparam int VOL_W      = 4;
  localparam int SH_W       = 5;
  localparam int MAX_VOL    = 12;
  localparam int BASE_SHIFT = 13;
  localparam int MID_OFFSET = 2048;
  localparam int SUM_W      = 22;

  // input beat layout
  localparam int IDX_LSB     = 0;
  localparam int VAL_LSB     = IDX_LSB + TBL_AW;
  localparam int KEY_LSB     = VAL_LSB + SMP_W;
  localparam int SHF_LSB     = KEY_LSB + KEY_W;
  localparam int VOL_LSB     = SHF_LSB + SHF_W;
  localparam int IN_USED_W   = VOL_LSB + VOL_W;
  localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = SMP_W;

  localparam logic OP_TABLE_WR = 1'b0;
  localparam logic OP_SAMPLE   = 1'b1;

  typedef logic [NOTE_W-1:0] note_idx_t;
  typedef logic [PH_W-1:0]   phase_t;

  function automatic phase_t note_step(input note_idx_t n);
    phase_t s;
    unique case (n)
      4'd0:    s = 32'd3110;
      4'd1:    s = 32'd3295;
      4'd2:    s = 32'd3491;
      4'd3:    s = 32'd3698;
      4'd4:    s = 32'd3918;
      4'd5:    s = 32'd4151;
      4'd6:    s = 32'd4398;
      4'd7:    s = 32'd4660;
      4'd8:    s = 32'd4937;
      4'd9:    s = 32'd5230;
      4'd10:   s = 32'd5542;
      4'd11:   s = 32'd5871;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

>>> hdl/polyphonic_dds_note_mixer.sv
// sample beat: after acceptance the sequencer runs a phase read, then per note a phase
//   update and one table read per board through the single read port of the wave table
//   memory, then drain and done; in_tready stays low until done hands on the result
// table write beat: no result, next beat accepted in the following cycle
// reset: synchronous active low, clears control, phase valid bits and the valid bit of the output register
// ----------------------------------------------------------------------------
// polyphonic_dds_note_mixer
// wavetable dds mixer, 12 note phases in memory, 1024-entry wave table memory
// ----------------------------------------------------------------------------
module polyphonic_dds_note_mixer #(
  parameter int BOARDS = pdnm_pkg::BOARDS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // table_index, table_value, key_states, octave_shift, volume_level, zero pad
  input  logic [pdnm_pkg::IN_TDATA_W-1:0]    in_tdata,
  // operation
  input  logic [0:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // sample_out
  output logic [pdnm_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int BRD_W = (BOARDS > 1) ? $clog2(BOARDS) : 1;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PH_RD  = 6'b000010,
    S_PH_UPD = 6'b000100,
    S_TB_RD  = 6'b001000,
    S_DRAIN  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t                             state_r, state_nxt;
  pdnm_pkg::note_idx_t                note_r, note_nxt;
  logic [BRD_W-1:0]                   brd_r, brd_nxt;
  logic [pdnm_pkg::KEY_W-1:0]         keys_r;
  logic [pdnm_pkg::SHF_W-1:0]         oct_r;
  logic [pdnm_pkg::VOL_W-1:0]         vol_r;
  pdnm_pkg::phase_t                   phase_cur_r;
  logic signed [pdnm_pkg::SUM_W-1:0]  sum_r;
  logic                               acc_en_r;
  logic                               out_valid_r;
  logic [pdnm_pkg::OUT_TDATA_W-1:0]   out_data_r;

  pdnm_pkg::phase_t                   ph_mem [pdnm_pkg::NOTES];
  logic [pdnm_pkg::NOTES-1:0]         ph_vld_r;
  pdnm_pkg::phase_t                   ph_q_r;
  logic                               ph_q_vld_r;
  logic signed [pdnm_pkg::SMP_W-1:0]  tbl_mem [pdnm_pkg::TBL_DEPTH];
  logic signed [pdnm_pkg::SMP_W-1:0]  tbl_q_r;

  logic                               in_acc;
  logic [pdnm_pkg::TBL_AW-1:0]        in_idx;
  logic signed [pdnm_pkg::SMP_W-1:0]  in_val;
  logic [pdnm_pkg::VOL_W-1:0]         in_vol;
  logic                               last_brd, last_note;
  logic                               held_any, held_cur;
  pdnm_pkg::phase_t                   ph_old, ph_new;
  logic                               ph_we, ph_ren;
  pdnm_pkg::note_idx_t                ph_raddr;
  logic [pdnm_pkg::SH_W-1:0]          tbl_sh;
  logic [pdnm_pkg::TBL_AW-1:0]        tbl_raddr;
  logic [pdnm_pkg::KEY_POS_W-1:0]     key_pos;
  logic signed [pdnm_pkg::SUM_W-1:0]  scaled;
  logic [pdnm_pkg::OUT_TDATA_W-1:0]   res;
  logic                               out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign in_idx     = in_tdata[pdnm_pkg::IDX_LSB +: pdnm_pkg::TBL_AW];
  assign in_val     = in_tdata[pdnm_pkg::VAL_LSB +: pdnm_pkg::SMP_W];
  assign in_vol     = in_tdata[pdnm_pkg::VOL_LSB +: pdnm_pkg::VOL_W];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  assign last_brd  = (brd_r == BRD_W'(BOARDS - 1));
  assign last_note = (note_r == pdnm_pkg::NOTE_W'(pdnm_pkg::NOTES - 1));

  // note held on any board
  always_comb begin
    logic [pdnm_pkg::NOTES-1:0] bkeys;
    held_any = 1'b0;
    for (int b = 0; b < BOARDS; b++) begin
      bkeys = keys_r[b*pdnm_pkg::NOTES +: pdnm_pkg::NOTES];
      if (!bkeys[note_r]) held_any = 1'b1;
    end
  end

  assign key_pos  = pdnm_pkg::KEY_POS_W'(brd_r) * pdnm_pkg::KEY_POS_W'(pdnm_pkg::NOTES)
                  + pdnm_pkg::KEY_POS_W'(note_r);
  assign held_cur = !keys_r[key_pos];

  assign ph_old = ph_q_vld_r ? ph_q_r : '0;
  assign ph_new = ph_old + pdnm_pkg::note_step(note_r);
  assign ph_we  = (state_r == S_PH_UPD) && held_any;

  assign ph_ren   = (state_r == S_PH_RD) || ((state_r == S_TB_RD) && last_brd && !last_note);
  assign ph_raddr = (state_r == S_PH_RD) ? note_r : note_r + pdnm_pkg::NOTE_W'(1);

  assign tbl_sh    = pdnm_pkg::SH_W'(pdnm_pkg::BASE_SHIFT) - pdnm_pkg::SH_W'(brd_r)
                   + pdnm_pkg::SH_W'(oct_r);
  assign tbl_raddr = pdnm_pkg::TBL_AW'(phase_cur_r >> tbl_sh);

  assign scaled = sum_r >>> (pdnm_pkg::VOL_W'(pdnm_pkg::MAX_VOL) - vol_r);
  assign res    = scaled[pdnm_pkg::OUT_TDATA_W-1:0]
                + pdnm_pkg::OUT_TDATA_W'(pdnm_pkg::MID_OFFSET);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    note_nxt  = note_r;
    brd_nxt   = brd_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser[0] == pdnm_pkg::OP_SAMPLE)) begin
          state_nxt = S_PH_RD;
          note_nxt  = '0;
        end
      end
      S_PH_RD: begin
        state_nxt = S_PH_UPD;
      end
      S_PH_UPD: begin
        state_nxt = S_TB_RD;
        brd_nxt   = '0;
      end
      S_TB_RD: begin
        if (last_brd) begin
          if (last_note) begin
            state_nxt = S_DRAIN;
          end else begin
            state_nxt = S_PH_UPD;
            note_nxt  = note_r + pdnm_pkg::NOTE_W'(1);
          end
        end else begin
          brd_nxt = brd_r + BRD_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      note_r      <= '0;
      brd_r       <= '0;
      acc_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
      ph_vld_r    <= '0;
      ph_q_vld_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      note_r   <= note_nxt;
      brd_r    <= brd_nxt;
      acc_en_r <= (state_r == S_TB_RD) && held_cur;
      if (ph_we) ph_vld_r[note_r] <= 1'b1;
      if (ph_ren) ph_q_vld_r <= ph_vld_r[ph_raddr];
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      keys_r <= in_tdata[pdnm_pkg::KEY_LSB +: pdnm_pkg::KEY_W];
      oct_r  <= in_tdata[pdnm_pkg::SHF_LSB +: pdnm_pkg::SHF_W];
      vol_r  <= (in_vol > pdnm_pkg::VOL_W'(pdnm_pkg::MAX_VOL))
              ? pdnm_pkg::VOL_W'(pdnm_pkg::MAX_VOL) : in_vol;
    end
    if (state_r == S_PH_UPD) phase_cur_r <= held_any ? ph_new : ph_old;
    if (in_acc) begin
      sum_r <= '0;
    end else if (acc_en_r) begin
      sum_r <= sum_r + pdnm_pkg::SUM_W'(tbl_q_r);
    end
    if ((state_r == S_DONE) && out_free) out_data_r <= res;
  end

  // phase memory
  always_ff @(posedge clk) begin
    if (ph_we) ph_mem[note_r] <= ph_new;
    if (ph_ren) ph_q_r <= ph_mem[ph_raddr];
  end

  // wave table memory
  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser[0] == pdnm_pkg::OP_TABLE_WR)) tbl_mem[in_idx] <= in_val;
    if (state_r == S_TB_RD) tbl_q_r <= tbl_mem[tbl_raddr];
  end

endmodule

>>> hdl/pdnm_checker.sv
// ----------------------------------------------------------------------------
// pdnm_checker
// port-level checks for the dds note mixer, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdnm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [pdnm_pkg::IN_TDATA_W-1:0]   in_tdata,
  input logic [0:0]                        in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [pdnm_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  logic in_beat;
  logic smp_beat;
  logic wr_beat;

  assign in_beat  = in_tvalid && in_tready;
  assign smp_beat = in_beat && (in_tuser[0] == pdnm_pkg::OP_SAMPLE);
  assign wr_beat  = in_beat && (in_tuser[0] == pdnm_pkg::OP_TABLE_WR);

  // stalled result holds
  `AM_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // sample beat occupies the block
  `AM_NEXT(a_smp_busy, clk, rst_n, smp_beat, !in_tready)
  // table write leaves the block ready and makes no result
  `AM_NEXT(a_wr_fast, clk, rst_n, wr_beat, in_tready && !($rose(out_tvalid)))
  // no result right after reset
  `AM_NEXT_ALWAYS(a_rst_clr, clk, !rst_n, !out_tvalid && in_tready)

  logic unused_ok;
  assign unused_ok = ^in_tdata;

endmodule

bind polyphonic_dds_note_mixer pdnm_checker u_pdnm_checker (.*);

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stream-level test of the polyphonic dds note mixer. a short table of
// directed beats comes first: table extremes, silent keys, every key held,
// out-of-range octave and volume, and negative sums that need a floor shift.
// then the whole wave table is filled and random table writes and sample
// beats follow. both sides pause at random, with stretches of no pauses.
// sample beats are checked against a local model of the mixer that keeps
// its own phases and wave table, or against the fixed value a directed row gives.
// sample beats never read an unwritten entry.
module tb_top;

  localparam int N_BOARDS     = pdnm_pkg::BOARDS_DEF;
  localparam int RANDOM_MIXED = 520;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 80;

  localparam logic [pdnm_pkg::PH_W-1:0] TUNING_STEP [pdnm_pkg::NOTES] = '{
    32'd3110, 32'd3295, 32'd3491, 32'd3698, 32'd3918, 32'd4151,
    32'd4398, 32'd4660, 32'd4937, 32'd5230, 32'd5542, 32'd5871
  };

  typedef struct packed {
    logic                        op;
    logic [pdnm_pkg::TBL_AW-1:0] idx;
    logic [pdnm_pkg::SMP_W-1:0]  val;
    logic [pdnm_pkg::KEY_W-1:0]  keys;
    logic [pdnm_pkg::SHF_W-1:0]  oct;
    logic [pdnm_pkg::VOL_W-1:0]  vol;
    logic                        has_want;
    logic [pdnm_pkg::SMP_W-1:0]  want;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [22] = '{
    '{pdnm_pkg::OP_SAMPLE,   10'h000, 16'h0000, 48'hFFFF_FFFF_FFFF, 4'd0,  4'd12, 1'b1, 16'h0800},
    '{pdnm_pkg::OP_TABLE_WR, 10'h000, 16'h7FFF, 48'h0,            4'd0,  4'd0,  1'b0, 16'h0000},
    '{pdnm_pkg::OP_TABLE_WR, 10'h3FF, 16'h8000, 48'h0,            4'd0,  4'd0,  1'b0, 16'h0000},
    '{pdnm_pkg::OP_TABLE_WR, 10'h2AA, 16'hAAAA, 48'h0,            4'd0,  4'd0,  1'b0, 16'h0000},
    '{pdnm_pkg::OP_TABLE_WR, 10'h155, 16'h5555, 48'h0,            4'd0,  4'd0,  1'b0, 16'h0000},
    '{pdnm_pkg::OP_TABLE_WR, 10'h001, 16'h0123, 48'h0,            4'd0,  4'd0,  1'b0, 16'h0000},
    '{pdnm_pkg::OP_TABLE_WR, 10'h002, 16'hFEDC, 48'h0,            4'd0,  4'd0,  1'b0, 16'h0000},
    '{pdnm_pkg::OP_TABLE_WR, 10'h003, 16'h1000, 48'h0,            4'd0,  4'd0,  1'b0, 16'h0000},
    '{pdnm_pkg::OP_TABLE_WR, 10'h004, 16'hF000, 48'h0,            4'd0,  4'd0,  1'b0, 16'h0000},
    '{pdnm_pkg::OP_TABLE_WR, 10'h005, 16'h0800, 48'h0,            4'd0,  4'd0,  1'b0, 16'h0000},
    '{pdnm_pkg::OP_TABLE_WR, 10'h006, 16'hFFFF, 48'h0,            4'd0,  4'd0,  1'b0, 16'h0000},
    '{pdnm_pkg::OP_SAMPLE,   10'h000, 16'h0000, 48'hFFFF_FFFF_FFFE, 4'd0,  4'd12, 1'b1, 16'h87FF},
    '{pdnm_pkg::OP_SAMPLE,   10'h000, 16'h0000, 48'h0000_0000_0000, 4'd0,  4'd0,  1'b0, 16'h0000},
    '{pdnm_pkg::OP_SAMPLE,   10'h000, 16'h0000, 48'h0000_0000_0000, 4'd15, 4'd15, 1'b0, 16'h0000},
    '{pdnm_pkg::OP_TABLE_WR, 10'h000, 16'h8000, 48'h0,            4'd0,  4'd0,  1'b0, 16'h0000},
    '{pdnm_pkg::OP_SAMPLE,   10'h000, 16'h0000, 48'hFFFF_FFFF_FFFE, 4'd15, 4'd0,  1'b1, 16'h07F8},
    '{pdnm_pkg::OP_TABLE_WR, 10'h000, 16'hFFFF, 48'h0,            4'd0,  4'd0,  1'b0, 16'h0000},
    '{pdnm_pkg::OP_SAMPLE,   10'h000, 16'h0000, 48'hFFFF_FFFF_FFFE, 4'd15, 4'd0,  1'b1, 16'h07FF},
    '{pdnm_pkg::OP_SAMPLE,   10'h000, 16'h0000, 48'hAAAA_AAAA_AAAA, 4'd3,  4'd7,  1'b0, 16'h0000},
    '{pdnm_pkg::OP_SAMPLE,   10'h000, 16'h0000, 48'h5555_5555_5555, 4'd9,  4'd12, 1'b0, 16'h0000},
    '{pdnm_pkg::OP_SAMPLE,   10'h000, 16'h0000, 48'h000F_FFFF_FFFF, 4'd4,  4'd12, 1'b0, 16'h0000},
    '{pdnm_pkg::OP_SAMPLE,   10'h000, 16'h0000, 48'hFFF0_0000_0FFF, 4'd12, 4'd11, 1'b0, 16'h0000}
  };

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [pdnm_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic [0:0]                       in_tuser;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [pdnm_pkg::OUT_TDATA_W-1:0] out_tdata;

  logic [pdnm_pkg::PH_W-1:0]         note_phase [pdnm_pkg::NOTES];
  logic signed [pdnm_pkg::SMP_W-1:0] wave_mem [pdnm_pkg::TBL_DEPTH];
  bit                                entry_written [pdnm_pkg::TBL_DEPTH];
  logic [pdnm_pkg::SMP_W-1:0]        expected_samples [$];
  int                                mismatch_count;
  int                                in_left, out_left;
  bit                                in_calm, out_calm;

  polyphonic_dds_note_mixer #(
    .BOARDS(N_BOARDS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pace(inout int left, inout bit calm);
    if (left == 0) begin
      left = $urandom_range(8, 60);
      calm = ($urandom_range(0, 3) == 0);
    end
    left--;
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic logic [pdnm_pkg::KEY_W-1:0] rand48();
    return pdnm_pkg::KEY_W'({$urandom, $urandom});
  endfunction

  function automatic logic [pdnm_pkg::KEY_W-1:0] draw_keys();
    logic [pdnm_pkg::KEY_W-1:0] k;
    int                         base;
    base = $urandom_range(0, N_BOARDS - 1) * pdnm_pkg::NOTES;
    case ($urandom_range(0, 5))
      0: k = '1;
      1: k = '0;
      2: k = rand48();
      3: k = rand48() | rand48() | rand48();
      4: begin
        k = '1;
        k[base +: pdnm_pkg::NOTES] = pdnm_pkg::NOTES'($urandom);
      end
      default: k = rand48() & rand48();
    endcase
    return k;
  endfunction

  // release any held key whose table read would land on an unwritten entry
  function automatic logic [pdnm_pkg::KEY_W-1:0] drop_unwritten_reads(
      input logic [pdnm_pkg::KEY_W-1:0] keys,
      input logic [pdnm_pkg::SHF_W-1:0] oct);
    logic [pdnm_pkg::PH_W-1:0]   ph;
    logic [pdnm_pkg::TBL_AW-1:0] idx;
    bit                          held;
    for (int n = 0; n < pdnm_pkg::NOTES; n++) begin
      held = 1'b0;
      for (int b = 0; b < N_BOARDS; b++)
        if (!keys[b*pdnm_pkg::NOTES + n]) held = 1'b1;
      if (held) begin
        ph = note_phase[n] + TUNING_STEP[n];
        for (int b = 0; b < N_BOARDS; b++) begin
          idx = pdnm_pkg::TBL_AW'(ph >> (pdnm_pkg::BASE_SHIFT - b + oct));
          if (!keys[b*pdnm_pkg::NOTES + n] && !entry_written[idx])
            keys[b*pdnm_pkg::NOTES + n] = 1'b1;
        end
      end
    end
    return keys;
  endfunction

  function automatic logic [pdnm_pkg::SMP_W-1:0] mix_sample(
      input logic [pdnm_pkg::KEY_W-1:0] keys,
      input logic [pdnm_pkg::SHF_W-1:0] oct,
      input logic [pdnm_pkg::VOL_W-1:0] vol);
    int                          acc;
    int                          scaled;
    int                          vsh;
    bit                          held;
    logic [pdnm_pkg::TBL_AW-1:0] idx;
    acc = 0;
    for (int n = 0; n < pdnm_pkg::NOTES; n++) begin
      held = 1'b0;
      for (int b = 0; b < N_BOARDS; b++)
        if (!keys[b*pdnm_pkg::NOTES + n]) held = 1'b1;
      if (held) begin
        note_phase[n] = note_phase[n] + TUNING_STEP[n];
        for (int b = 0; b < N_BOARDS; b++) begin
          if (!keys[b*pdnm_pkg::NOTES + n]) begin
            idx = pdnm_pkg::TBL_AW'(note_phase[n] >> (pdnm_pkg::BASE_SHIFT - b + oct));
            acc += wave_mem[idx];
          end
        end
      end
    end
    vsh = (vol > pdnm_pkg::MAX_VOL) ? 0 : pdnm_pkg::MAX_VOL - vol;
    scaled = acc >>> vsh;
    return scaled[pdnm_pkg::SMP_W-1:0] + pdnm_pkg::SMP_W'(pdnm_pkg::MID_OFFSET);
  endfunction

  function automatic logic [pdnm_pkg::IN_TDATA_W-1:0] pack_beat(
      input logic [pdnm_pkg::TBL_AW-1:0] idx,
      input logic [pdnm_pkg::SMP_W-1:0]  val,
      input logic [pdnm_pkg::KEY_W-1:0]  keys,
      input logic [pdnm_pkg::SHF_W-1:0]  oct,
      input logic [pdnm_pkg::VOL_W-1:0]  vol);
    logic [pdnm_pkg::IN_TDATA_W-1:0] d;
    d = '0;
    d[pdnm_pkg::IDX_LSB +: pdnm_pkg::TBL_AW] = idx;
    d[pdnm_pkg::VAL_LSB +: pdnm_pkg::SMP_W]  = val;
    d[pdnm_pkg::KEY_LSB +: pdnm_pkg::KEY_W]  = keys;
    d[pdnm_pkg::SHF_LSB +: pdnm_pkg::SHF_W]  = oct;
    d[pdnm_pkg::VOL_LSB +: pdnm_pkg::VOL_W]  = vol;
    return d;
  endfunction

  task automatic send_beat(input logic op, input logic [pdnm_pkg::TBL_AW-1:0] idx,
                           input logic [pdnm_pkg::SMP_W-1:0] val,
                           input logic [pdnm_pkg::KEY_W-1:0] keys,
                           input logic [pdnm_pkg::SHF_W-1:0] oct,
                           input logic [pdnm_pkg::VOL_W-1:0] vol,
                           input logic has_want, input logic [pdnm_pkg::SMP_W-1:0] want);
    int                         gap;
    logic [pdnm_pkg::SMP_W-1:0] pred;
    gap = pace(in_left, in_calm);
    if (op == pdnm_pkg::OP_SAMPLE) keys = drop_unwritten_reads(keys, oct);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= pack_beat(idx, val, keys, oct, vol);
    do @(posedge clk); while (in_tready !== 1'b1);
    if (op == pdnm_pkg::OP_SAMPLE) begin
      pred = mix_sample(keys, oct, vol);
      expected_samples.push_back(has_want ? want : pred);
    end else begin
      wave_mem[idx]      = val;
      entry_written[idx] = 1'b1;
    end
  endtask

  initial begin : stimulus
    logic [pdnm_pkg::SHF_W-1:0] oct;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = pdnm_pkg::OP_TABLE_WR;
    out_tready     = 1'b0;
    mismatch_count = 0;
    in_left        = 0;
    out_left       = 0;
    in_calm        = 1'b0;
    out_calm       = 1'b0;
    foreach (note_phase[n]) note_phase[n] = '0;
    foreach (wave_mem[i]) begin
      wave_mem[i]      = '0;
      entry_written[i] = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i])
      send_beat(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].val,
                DIRECTED_ROWS[i].keys, DIRECTED_ROWS[i].oct, DIRECTED_ROWS[i].vol,
                DIRECTED_ROWS[i].has_want, DIRECTED_ROWS[i].want);

    // fill the table so every later read hits a written entry
    for (int i = 0; i < pdnm_pkg::TBL_DEPTH; i++)
      send_beat(pdnm_pkg::OP_TABLE_WR, pdnm_pkg::TBL_AW'(i), pdnm_pkg::SMP_W'($urandom),
                rand48(), pdnm_pkg::SHF_W'($urandom), pdnm_pkg::VOL_W'($urandom),
                1'b0, '0);

    for (int i = 0; i < RANDOM_MIXED; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        send_beat(pdnm_pkg::OP_TABLE_WR, pdnm_pkg::TBL_AW'($urandom),
                  pdnm_pkg::SMP_W'($urandom), rand48(), pdnm_pkg::SHF_W'($urandom),
                  pdnm_pkg::VOL_W'($urandom), 1'b0, '0);
      end else begin
        oct = ($urandom_range(0, 3) == 0) ? pdnm_pkg::SHF_W'($urandom_range(10, 15))
                                          : pdnm_pkg::SHF_W'($urandom_range(0, 9));
        send_beat(pdnm_pkg::OP_SAMPLE, pdnm_pkg::TBL_AW'($urandom),
                  pdnm_pkg::SMP_W'($urandom), draw_keys(), oct,
                  pdnm_pkg::VOL_W'($urandom_range(0, 15)), 1'b0, '0);
      end
    end
    in_tvalid <= 1'b0;

    while (expected_samples.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin : result_sink
    int                         stall;
    logic [pdnm_pkg::SMP_W-1:0] want;
    wait (rst_n === 1'b1);
    forever begin
      stall = pace(out_left, out_calm);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      if (expected_samples.size() == 0) begin
        $error("sample_out: expected none, actual %h", out_tdata);
        mismatch_count++;
      end else begin
        want = expected_samples.pop_front();
        if (out_tdata !== want) begin
          $error("sample_out: expected %h, actual %h", want, out_tdata);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    wait (rst_n === 1'b1);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid === 1'b1 && in_tready === 1'b1) ||
          (out_tvalid === 1'b1 && out_tready === 1'b1))
        idle = 0;
      else
        idle++;
    end
    $display("Mismatches found");
    $finish;
  end

endmodule
